// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Request and status codes and fixed port widths of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int REQ_W   = 3;
	localparam int WORD_W  = 32;
	localparam int RANGE_W = 4;
	localparam int FILL_W  = 5;
	localparam int STAT_W  = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

// ===== rtl/bounded_deque_with_range_erase.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_range_erase
// Fixed-capacity double-ended queue held as a ring in one RAM, with
// push/pop/peek at both ends and inclusive range erase.
//
//   channel   signals                                          handshake
//   request   req_type data_word range_start range_end         start & !busy
//   result    read_word status fill_count                      done (1 cycle)
//
// Push, pop and peek go through accept (RAM access issued), then result.
// Erase moves the entries behind the range down over it; the RAM streams
// one read and one write per cycle while closing the gap. Refused
// requests go through accept, then result. Reset empties the deque at
// once; no clearing pass. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
module bounded_deque_with_range_erase
	import bdq_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int DATA_W   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [WORD_W-1:0]  data_word,
	input  logic [RANGE_W-1:0] range_start,
	input  logic [RANGE_W-1:0] range_end,
	output logic               done,
	output logic [WORD_W-1:0]  read_word,
	output logic [STAT_W-1:0]  status,
	output logic [FILL_W-1:0]  fill_count
);

	localparam int PTR_W = $clog2(CAPACITY > 1 ? CAPACITY : 2);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (SUM_W > RANGE_W) ? SUM_W : RANGE_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ERASE = 2'd1;
	localparam logic [1:0] S_RESP  = 2'd2;

	function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
		return r[PTR_W-1:0];
	endfunction

	logic [1:0]         state_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAT_W-1:0]  status_q;
	logic               rd_sel_q;
	logic [PTR_W-1:0]   src_q;
	logic [PTR_W-1:0]   dst_q;
	logic [CNT_W-1:0]   left_q;
	logic               pend_q;

	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic               erase_ok;
	logic [SUM_W-1:0]   head_x;
	logic [PTR_W-1:0]   back_wr_addr;
	logic [PTR_W-1:0]   back_rd_addr;
	logic [PTR_W-1:0]   front_wr_addr;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [PTR_W-1:0]   ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_full  = (count_q >= CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign erase_ok = (range_start <= range_end) &&
	                  (CMP_W'(range_end) < CMP_W'(count_q));
	assign head_x   = SUM_W'(head_q);

	assign back_wr_addr  = wrap(head_x + SUM_W'(count_q));
	assign back_rd_addr  = wrap(head_x + SUM_W'(count_q) - SUM_W'(1));
	assign front_wr_addr = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - PTR_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		ram_raddr = src_q;
		if (accept) begin
			case (req_type)
				REQ_PUSH_BACK: begin
					ram_we    = !is_full;
					ram_waddr = back_wr_addr;
					ram_wdata = DATA_W'(data_word);
				end
				REQ_PUSH_FRONT: begin
					ram_we    = !is_full;
					ram_waddr = front_wr_addr;
					ram_wdata = DATA_W'(data_word);
				end
				REQ_POP_FRONT, REQ_PEEK_FRONT: ram_raddr = head_q;
				REQ_POP_BACK, REQ_PEEK_BACK:   ram_raddr = back_rd_addr;
				default: ;
			endcase
		end else if (state_q == S_ERASE) begin
			ram_we = pend_q;
		end
	end

	bdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
			rd_sel_q <= 1'b0;
			left_q   <= '0;
			pend_q   <= 1'b0;
			src_q    <= '0;
			dst_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_RESP;
						status_q <= ST_OK;
						rd_sel_q <= 1'b0;
						case (req_type)
							REQ_PUSH_BACK: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							REQ_PUSH_FRONT: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									head_q  <= front_wr_addr;
									count_q <= count_q + CNT_W'(1);
								end
							end
							REQ_POP_FRONT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									rd_sel_q <= 1'b1;
									head_q   <= wrap(head_x + SUM_W'(1));
									count_q  <= count_q - CNT_W'(1);
								end
							end
							REQ_POP_BACK: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									rd_sel_q <= 1'b1;
									count_q  <= count_q - CNT_W'(1);
								end
							end
							REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									rd_sel_q <= 1'b1;
								end
							end
							REQ_ERASE: begin
								if (!erase_ok) begin
									status_q <= ST_RANGE;
								end else begin
									state_q <= S_ERASE;
									src_q   <= wrap(head_x + SUM_W'(range_end) + SUM_W'(1));
									dst_q   <= wrap(head_x + SUM_W'(range_start));
									left_q  <= count_q - CNT_W'(range_end) - CNT_W'(1);
									count_q <= count_q - (CNT_W'(range_end) -
									           CNT_W'(range_start) + CNT_W'(1));
									pend_q  <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_ERASE: begin
					// advance the read side while entries remain, drain the write side behind it
					if (pend_q) begin
						dst_q <= wrap(SUM_W'(dst_q) + SUM_W'(1));
					end
					if (left_q != '0) begin
						src_q  <= wrap(SUM_W'(src_q) + SUM_W'(1));
						left_q <= left_q - CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = (state_q == S_RESP);
	assign read_word  = (done && rd_sel_q) ? WORD_W'(ram_rdata) : '0;
	assign status     = status_q;
	assign fill_count = FILL_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (count_q == '0))
		else $error("empty status with entries stored");

endmodule

// ===== rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
